/* sv/assert_macros.svh */
// Assertion helper macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// The condition must never be seen.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("assertion failed");

`endif

/* sv/sdbt_pkg.sv */
// ----------------------------------------------------------------------------
// sdbt_pkg
// Shared types, codes and helper functions of the SD SPI block transfer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sdbt_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int R1_TRIES    = 10;
	localparam int COUNT_BITS  = 16;
	localparam int BI_W        = $clog2(BLOCK_BYTES) + 1;
	localparam logic [COUNT_BITS-1:0] TICK_MAX = {COUNT_BITS{1'b1}};

	// Request kinds.
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_XCHG  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOT_RDY  = 3'd1;
	localparam logic [2:0] ST_CMD_FAIL = 3'd2;
	localparam logic [2:0] ST_TIMEOUT  = 3'd3;
	localparam logic [2:0] ST_RD_FAIL  = 3'd4;
	localparam logic [2:0] ST_WR_FAIL  = 3'd5;

	// Command indexes.
	localparam logic [5:0] CMD12 = 6'd12;
	localparam logic [5:0] CMD17 = 6'd17;
	localparam logic [5:0] CMD18 = 6'd18;
	localparam logic [5:0] CMD23 = 6'd23;
	localparam logic [5:0] CMD24 = 6'd24;
	localparam logic [5:0] CMD25 = 6'd25;
	localparam logic [5:0] CMD55 = 6'd55;

	// Tokens and fill bytes.
	localparam logic [7:0] BYTE_FILL  = 8'hFF;
	localparam logic [7:0] TOK_START  = 8'hFE;
	localparam logic [7:0] TOK_MULTI  = 8'hFC;
	localparam logic [7:0] TOK_STOP   = 8'hFD;
	localparam logic [4:0] DRESP_MASK = 5'h1F;
	localparam logic [4:0] DRESP_OK   = 5'h05;

	// Configuration register indexes.
	localparam logic [2:0] REG_HIGH_CAP = 3'd0;
	localparam logic [2:0] REG_CARD_RDY = 3'd1;
	localparam logic [2:0] REG_IS_MMC   = 3'd2;
	localparam logic [2:0] REG_CMD_TO   = 3'd3;
	localparam logic [2:0] REG_RD_TO    = 3'd4;
	localparam logic [2:0] REG_WR_TO    = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        op_write;
		logic [31:0] sector;
		logic [15:0] block_count;
		logic [7:0]  rx_byte;
		logic [7:0]  wr_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       cs_active;
		logic [7:0] rd_byte;
		logic       rd_valid;
		logic       wr_request;
		logic       done_res;
		logic [2:0] status;
		logic       busy_res;
	} out_item_t;

	// Classified item as held in the queue.
	typedef struct packed {
		logic        is_start;
		logic        is_xchg;
		logic        is_tick;
		logic        op_write;
		logic [31:0] sector;
		logic [15:0] block_count;
		logic [7:0]  rx_byte;
		logic [7:0]  wr_byte;
	} q_entry_t;

	typedef struct packed {
		logic        high_capacity;
		logic        card_ready;
		logic        is_mmc;
		logic [15:0] cmd_timeout_ticks;
		logic [15:0] read_timeout_ticks;
		logic [15:0] write_timeout_ticks;
	} cfg_t;

	// CRC7 (polynomial 0x09) advanced over one byte, MSB first.
	function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
		logic [6:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = b[i] ^ c[6];
			c  = {c[5:0], 1'b0};
			if (fb) begin
				c = c ^ 7'h09;
			end
		end
		return c;
	endfunction

	// Byte idx of a command frame; the last one carries the CRC and end bit.
	function automatic logic [7:0] frame_byte(input logic [5:0] cmd, input logic [31:0] arg,
		input logic [2:0] idx, input logic [6:0] crc);
		logic [7:0] b;
		case (idx)
			3'd0:    b = {2'b01, cmd};
			3'd1:    b = arg[31:24];
			3'd2:    b = arg[23:16];
			3'd3:    b = arg[15:8];
			3'd4:    b = arg[7:0];
			default: b = {crc, 1'b1};
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* sv/sdbt_front.sv */
// ----------------------------------------------------------------------------
// sdbt_front
// Accepts input items, classifies the request kind and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbt_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  sdbt_pkg::in_item_t   in_data,
	output logic                 q_valid,
	output sdbt_pkg::q_entry_t   q_head,
	input  wire                  q_pop
);
	import sdbt_pkg::*;

	q_entry_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	q_entry_t   cls;
	logic       push;

	// Decode the request kind; unknown kinds carry no flag and are ignored later.
	always_comb begin
		cls             = '0;
		cls.is_start    = (in_data.req_type == REQ_START);
		cls.is_xchg     = (in_data.req_type == REQ_XCHG);
		cls.is_tick     = (in_data.req_type == REQ_TICK);
		cls.op_write    = in_data.op_write;
		cls.sector      = in_data.sector;
		cls.block_count = in_data.block_count;
		cls.rx_byte     = in_data.rx_byte;
		cls.wr_byte     = in_data.wr_byte;
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_head   = slot_q[rd_ptr_q];

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

`default_nettype wire

/* sv/sdbt_engine.sv */
// ----------------------------------------------------------------------------
// sdbt_engine
// Protocol sequencer: one queued item per cycle to a result register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbt_engine (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sdbt_pkg::cfg_t       cfg,
	input  wire                  q_valid,
	input  sdbt_pkg::q_entry_t   q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire                  out_stall,
	output sdbt_pkg::out_item_t  out_data
);
	import sdbt_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_CMD_WAIT, PH_CMD_SEND, PH_CMD_STUFF, PH_CMD_RESP,
		PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC,
		PH_WR_READY, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_FLUSH,
		PH_WR_STOPTOK, PH_WR_DRAIN, PH_STOP_END
	} phase_t;

	phase_t          phase_q, n_phase;
	logic [5:0]      cmd_q, n_cmd;
	logic [31:0]     arg_q, n_arg;
	logic [6:0]      crc_q, n_crc;
	logic [BI_W-1:0] bi_q, n_bi;
	logic [15:0]     blocks_q, n_blocks;
	logic [31:0]     addr_q, n_addr;
	logic [3:0]      tries_q, n_tries;
	logic [COUNT_BITS-1:0] tick_q, n_tick;
	logic [2:0]      fstat_q, n_fstat;
	logic            out_valid_q;
	out_item_t       out_q, res;
	logic            advance;

	logic            do_disp, do_cmd, do_send;
	logic [7:0]      disp_r;
	logic [5:0]      cmd_sel;
	logic [31:0]     arg_sel;
	logic [7:0]      fb;
	logic            multi_wr;
	logic            multi_rd;
	logic [7:0]      r;

	assign advance   = q_valid && (!out_valid_q || !out_stall);
	assign q_pop     = advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign multi_wr  = (cmd_q == CMD25);
	assign multi_rd  = (cmd_q == CMD18);
	assign r         = q_head.rx_byte;

	// Next state and result of the item at the head of the queue.
	always_comb begin
		n_phase  = phase_q;
		n_cmd    = cmd_q;
		n_arg    = arg_q;
		n_crc    = crc_q;
		n_bi     = bi_q;
		n_blocks = blocks_q;
		n_addr   = addr_q;
		n_tries  = tries_q;
		n_tick   = tick_q;
		n_fstat  = fstat_q;
		res      = '0;
		do_disp  = 1'b0;
		do_cmd   = 1'b0;
		do_send  = 1'b0;
		disp_r   = BYTE_FILL;
		cmd_sel  = CMD12;
		arg_sel  = '0;
		fb       = '0;

		if (q_head.is_start) begin
			if (phase_q == PH_IDLE) begin
				if (!cfg.card_ready || q_head.block_count == 16'd0) begin
					res.done_res = 1'b1;
					res.status   = ST_NOT_RDY;
				end else begin
					n_blocks = q_head.block_count;
					n_addr   = cfg.high_capacity ? q_head.sector : {q_head.sector[22:0], 9'd0};
					do_cmd   = 1'b1;
					arg_sel  = n_addr;
					if (!q_head.op_write) begin
						cmd_sel = (q_head.block_count == 16'd1) ? CMD17 : CMD18;
					end else if (q_head.block_count == 16'd1) begin
						cmd_sel = CMD24;
					end else if (!cfg.is_mmc) begin
						cmd_sel = CMD55;
						arg_sel = '0;
					end else begin
						cmd_sel = CMD25;
					end
				end
			end
		end else if (q_head.is_tick) begin
			if (phase_q != PH_IDLE && tick_q < TICK_MAX) begin
				n_tick = tick_q + 1'b1;
			end
		end else if (q_head.is_xchg && phase_q != PH_IDLE) begin
			case (phase_q)
				PH_CMD_WAIT: begin
					if (r == BYTE_FILL) begin
						n_bi    = '0;
						do_send = 1'b1;
					end else if (tick_q >= cfg.cmd_timeout_ticks) begin
						do_disp = 1'b1;
						disp_r  = BYTE_FILL;
					end else begin
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					end
				end
				PH_CMD_SEND: begin
					res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					if (bi_q < BI_W'(6)) begin
						do_send = 1'b1;
					end else if (cmd_q == CMD12) begin
						n_phase = PH_CMD_STUFF;
					end else begin
						n_tries = '0;
						n_phase = PH_CMD_RESP;
					end
				end
				PH_CMD_STUFF: begin
					n_tries = '0;
					res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					n_phase = PH_CMD_RESP;
				end
				PH_CMD_RESP: begin
					n_tries = tries_q + 1'b1;
					if (r[7] && n_tries < 4'(R1_TRIES)) begin
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					end else begin
						do_disp = 1'b1;
						disp_r  = r;
					end
				end
				PH_RD_TOKEN: begin
					if (tick_q > cfg.read_timeout_ticks || (r != BYTE_FILL && r != TOK_START))
							begin
						if (multi_rd) begin
							n_fstat = (tick_q > cfg.read_timeout_ticks) ? ST_TIMEOUT : ST_RD_FAIL;
							do_cmd  = 1'b1;
							cmd_sel = CMD12;
						end else begin
							n_phase = PH_IDLE;
							res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
							res.status = (tick_q > cfg.read_timeout_ticks) ? ST_TIMEOUT : ST_RD_FAIL;
						end
					end else begin
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
						if (r == TOK_START) begin
							n_bi    = '0;
							n_phase = PH_RD_DATA;
						end
					end
				end
				PH_RD_DATA: begin
					res.rd_byte  = r;
					res.rd_valid = 1'b1;
					res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					n_bi = bi_q + 1'b1;
					if (n_bi >= BI_W'(BLOCK_BYTES)) begin
						n_bi    = '0;
						n_phase = PH_RD_CRC;
					end
				end
				PH_RD_CRC: begin
					if (bi_q == '0) begin
						n_bi = BI_W'(1);
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					end else begin
						n_blocks = blocks_q - 1'b1;
						if (n_blocks != 16'd0) begin
							n_tick  = '0;
							n_phase = PH_RD_TOKEN;
							res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
						end else if (multi_rd) begin
							n_fstat = ST_OK;
							do_cmd  = 1'b1;
							cmd_sel = CMD12;
						end else begin
							n_phase = PH_IDLE;
							res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
							res.status = ST_OK;
						end
					end
				end
				PH_WR_READY, PH_WR_FLUSH: begin
					if (r == BYTE_FILL) begin
						if (phase_q == PH_WR_READY) begin
							res.tx_byte = multi_wr ? TOK_MULTI : TOK_START;
							res.tx_valid = 1'b1; res.cs_active = 1'b1;
							res.wr_request = 1'b1;
							n_bi    = '0;
							n_phase = PH_WR_DATA;
						end else if (multi_wr) begin
							res.tx_byte = TOK_STOP; res.tx_valid = 1'b1; res.cs_active = 1'b1;
							n_phase = PH_WR_STOPTOK;
						end else begin
							n_phase = PH_IDLE;
							res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
							res.status = ST_OK;
						end
					end else if (tick_q >= cfg.write_timeout_ticks) begin
						if (multi_wr) begin
							n_fstat = ST_TIMEOUT;
							res.tx_byte = TOK_STOP; res.tx_valid = 1'b1; res.cs_active = 1'b1;
							n_phase = PH_STOP_END;
						end else begin
							n_phase = PH_IDLE;
							res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
							res.status = ST_TIMEOUT;
						end
					end else begin
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					end
				end
				PH_WR_DATA: begin
					res.tx_byte = q_head.wr_byte; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					n_bi = bi_q + 1'b1;
					if (n_bi < BI_W'(BLOCK_BYTES)) begin
						res.wr_request = 1'b1;
					end else begin
						n_bi    = '0;
						n_phase = PH_WR_CRC;
					end
				end
				PH_WR_CRC: begin
					n_bi = bi_q + 1'b1;
					res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					if (n_bi >= BI_W'(3)) begin
						n_phase = PH_WR_RESP;
					end
				end
				PH_WR_RESP: begin
					if ((r[4:0] & DRESP_MASK) != DRESP_OK) begin
						if (multi_wr) begin
							n_fstat = ST_WR_FAIL;
							res.tx_byte = TOK_STOP; res.tx_valid = 1'b1; res.cs_active = 1'b1;
							n_phase = PH_STOP_END;
						end else begin
							n_phase = PH_IDLE;
							res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
							res.status = ST_WR_FAIL;
						end
					end else begin
						n_tick = '0;
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
						n_phase = PH_WR_FLUSH;
						if (multi_wr) begin
							n_blocks = blocks_q - 1'b1;
							if (n_blocks != 16'd0) begin
								n_phase = PH_WR_READY;
							end
						end
					end
				end
				PH_WR_STOPTOK: begin
					n_tick = '0;
					res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					n_phase = PH_WR_DRAIN;
				end
				PH_WR_DRAIN: begin
					if (r == BYTE_FILL || tick_q >= cfg.write_timeout_ticks) begin
						n_phase = PH_IDLE;
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
						res.status = ST_OK;
					end else begin
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
					end
				end
				PH_STOP_END: begin
					n_phase = PH_IDLE;
					res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
					res.status = fstat_q;
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end

		// Dispatch on the R1 reply of the current command.
		if (do_disp) begin
			case (cmd_q)
				CMD17, CMD18, CMD24, CMD25: begin
					if (disp_r != 8'd0) begin
						n_phase = PH_IDLE;
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
						res.status = ST_CMD_FAIL;
					end else begin
						n_tick  = '0;
						res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
						n_phase = (cmd_q == CMD24 || cmd_q == CMD25) ? PH_WR_READY : PH_RD_TOKEN;
					end
				end
				CMD12: begin
					n_phase = PH_IDLE;
					res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
					res.status = fstat_q;
				end
				CMD55: begin
					do_cmd = 1'b1;
					if (disp_r > 8'd1) begin
						cmd_sel = CMD25;
						arg_sel = addr_q;
					end else begin
						cmd_sel = CMD23;
						arg_sel = {16'd0, blocks_q};
					end
				end
				CMD23: begin
					do_cmd  = 1'b1;
					cmd_sel = CMD25;
					arg_sel = addr_q;
				end
				default: begin
					n_phase = PH_IDLE;
					res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.done_res = 1'b1;
					res.status = ST_CMD_FAIL;
				end
			endcase
		end

		// Begin a command: the stop command goes out at once, others wait for ready.
		if (do_cmd) begin
			n_cmd = cmd_sel;
			n_arg = arg_sel;
			if (cmd_sel == CMD12) begin
				n_bi    = '0;
				do_send = 1'b1;
			end else begin
				n_tick  = '0;
				res.tx_byte = BYTE_FILL; res.tx_valid = 1'b1; res.cs_active = 1'b1;
				n_phase = PH_CMD_WAIT;
			end
		end

		// Send one frame byte; the CRC is built a byte at a time as the head goes out.
		if (do_send) begin
			fb    = frame_byte(n_cmd, n_arg, n_bi[2:0], n_crc);
			n_crc = crc7_byte((n_bi == '0) ? 7'd0 : n_crc, fb);
			n_bi  = n_bi + 1'b1;
			res.tx_byte = fb; res.tx_valid = 1'b1; res.cs_active = 1'b1;
			n_phase = PH_CMD_SEND;
		end

		res.busy_res = (n_phase != PH_IDLE);
		if (!res.tx_valid) begin
			res.cs_active = res.busy_res;
		end
	end

	// Sequencer state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cmd_q       <= '0;
			arg_q       <= '0;
			crc_q       <= '0;
			bi_q        <= '0;
			blocks_q    <= '0;
			addr_q      <= '0;
			tries_q     <= '0;
			tick_q      <= '0;
			fstat_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= n_phase;
				cmd_q       <= n_cmd;
				arg_q       <= n_arg;
				crc_q       <= n_crc;
				bi_q        <= n_bi;
				blocks_q    <= n_blocks;
				addr_q      <= n_addr;
				tries_q     <= n_tries;
				tick_q      <= n_tick;
				fstat_q     <= n_fstat;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

/* sv/sd_spi_block_transfer_engine.sv */
// An accepted item is written to the queue, then its result to the result register.
// Throughput: the sequencer takes one queued item per cycle unless output stalls.
// A two-entry queue and the result register let each side stall on its own.
// Reset: arst_n resets sequencer, queue count and config at once; no clearing pass.
// ----------------------------------------------------------------------------
// sd_spi_block_transfer_engine
// SD SPI-mode host block transfer engine with an APB-style register port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sd_spi_block_transfer_engine (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  sdbt_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output sdbt_pkg::out_item_t  out_data,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [4:0]           paddr,
	input  wire  [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import sdbt_pkg::*;

	cfg_t       cfg_q;
	logic       q_valid;
	q_entry_t   q_head;
	logic       q_pop;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_capacity       <= 1'b0;
			cfg_q.card_ready          <= 1'b0;
			cfg_q.is_mmc              <= 1'b0;
			cfg_q.cmd_timeout_ticks   <= 16'd500;
			cfg_q.read_timeout_ticks  <= 16'd200;
			cfg_q.write_timeout_ticks <= 16'd500;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_HIGH_CAP: cfg_q.high_capacity       <= pwdata[0];
				REG_CARD_RDY: cfg_q.card_ready          <= pwdata[0];
				REG_IS_MMC:   cfg_q.is_mmc              <= pwdata[0];
				REG_CMD_TO:   cfg_q.cmd_timeout_ticks   <= pwdata[15:0];
				REG_RD_TO:    cfg_q.read_timeout_ticks  <= pwdata[15:0];
				REG_WR_TO:    cfg_q.write_timeout_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_idx)
			REG_HIGH_CAP: prdata = {31'd0, cfg_q.high_capacity};
			REG_CARD_RDY: prdata = {31'd0, cfg_q.card_ready};
			REG_IS_MMC:   prdata = {31'd0, cfg_q.is_mmc};
			REG_CMD_TO:   prdata = {16'd0, cfg_q.cmd_timeout_ticks};
			REG_RD_TO:    prdata = {16'd0, cfg_q.read_timeout_ticks};
			REG_WR_TO:    prdata = {16'd0, cfg_q.write_timeout_ticks};
			default:      prdata = 32'd0;
		endcase
	end

	sdbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	sdbt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// A finishing result releases chip select and reports idle.
	`ASSERT_IMPLY(a_done_idle, clk, arst_n, out_valid && out_data.done_res,
		!out_data.busy_res && !out_data.cs_active)
	// Read payload only arrives with a requested exchange.
	`ASSERT_IMPLY(a_rd_xchg, clk, arst_n, out_valid && out_data.rd_valid,
		out_data.tx_valid && out_data.cs_active)
	// A status code is only reported on a finishing result.
	`ASSERT_NEVER(a_status_done, clk, arst_n,
		out_valid && !out_data.done_res && (out_data.status != ST_OK))

endmodule

`default_nettype wire
